/* rtl/core/ctsk_pkg.sv */
// shared types and constants of the character stream tokenizer
// token and request structs, kind codes, counter widths and saturation helper
// no dependencies
package ctsk_pkg;

  localparam int CntBits    = 16;
  localparam int LenBits    = 16;
  localparam int OutBits    = 16;
  localparam int QDepth     = 4;
  localparam int QPtrBits   = $clog2(QDepth);
  localparam int RegIdxBits = 1;
  localparam int AddrBits   = RegIdxBits + 2;

  localparam logic [RegIdxBits-1:0] RegTabWidth = '0;
  localparam logic [3:0]            TabReset    = 4'd4;

  typedef enum logic [4:0] {
    TK_IDENT   = 5'd0,
    TK_KEYWORD = 5'd1,
    TK_INVALID = 5'd2,
    TK_EOF     = 5'd3,
    TK_NUMBER  = 5'd4,
    TK_STRING  = 5'd5,
    TK_PLUS    = 5'd6,
    TK_MUL     = 5'd7,
    TK_INC     = 5'd8,
    TK_DEC     = 5'd9,
    TK_EXP     = 5'd10,
    TK_MINUS   = 5'd11,
    TK_SLASH   = 5'd12,
    TK_EQUAL   = 5'd13,
    TK_ASSIGN  = 5'd14,
    TK_LTE     = 5'd15,
    TK_GTE     = 5'd16,
    TK_LPAREN  = 5'd17,
    TK_RPAREN  = 5'd18,
    TK_LBRACE  = 5'd19,
    TK_RBRACE  = 5'd20,
    TK_SEMI    = 5'd21
  } tok_kind_t;

  typedef enum logic [3:0] {
    PK_NONE, PK_WORD, PK_NUMBER, PK_STRING,
    PK_PLUS, PK_MINUS, PK_STAR, PK_EQ, PK_GT, PK_LT
  } pend_kind_t;

  typedef struct packed {
    tok_kind_t          kind;
    logic [OutBits-1:0] line;
    logic [OutBits-1:0] column;
    logic [OutBits-1:0] length;
    logic [7:0]         first_byte;
    logic               last;
  } token_t;

  // up to two tokens per request: the one that closes a pending token, then a fresh one
  typedef struct packed {
    logic   pend_valid;
    token_t pend_tok;
    logic   new_valid;
    token_t new_tok;
  } tok_push_t;

  function automatic logic [OutBits-1:0] sat_out(input logic [CntBits-1:0] v);
    logic [32:0] ext;
    ext = 33'(v);
    return (ext > 33'(2**OutBits - 1)) ? '1 : ext[OutBits-1:0];
  endfunction

endpackage

/* rtl/core/ctsk_apb_regs.sv */
// configuration register block: tab width behind an apb-style port
// depends on ctsk_pkg
module ctsk_apb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ctsk_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [3:0]                   tab_width
);
  import ctsk_pkg::*;

  logic                  wr_en;
  logic [RegIdxBits-1:0] reg_idx;

  assign reg_idx = paddr[AddrBits-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && (reg_idx == RegTabWidth);

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width <= TabReset;
    end else if (wr_en) begin
      tab_width <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == RegTabWidth) begin
      prdata = {28'd0, tab_width};
    end
  end

endmodule

/* rtl/core/ctsk_lexer.sv */
// tokenizer state and single-pass next-state logic for one source byte
// depends on ctsk_pkg
module ctsk_lexer (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          char_code,
  input  logic [3:0]          tab_width,
  output ctsk_pkg::tok_push_t push
);
  import ctsk_pkg::*;

  localparam int NumKw = 5;
  localparam logic [63:0] KwText [NumKw] = '{
    "function", {"print", 24'h0}, {"if", 48'h0}, {"else", 32'h0}, {"elseif", 16'h0}
  };
  localparam logic [3:0] KwLen [NumKw] = '{4'd8, 4'd5, 4'd2, 4'd4, 4'd6};

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChLpar  = 8'h28;
  localparam logic [7:0] ChRpar  = 8'h29;
  localparam logic [7:0] ChLbr   = 8'h7B;
  localparam logic [7:0] ChRbr   = 8'h7D;
  localparam logic [7:0] ChSemi  = 8'h3B;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic [NumKw-1:0] kw_filter(input logic [NumKw-1:0] cands,
                                                 input logic [LenBits-1:0] idx,
                                                 input logic [7:0] c);
    logic [NumKw-1:0] keep;
    keep = '0;
    for (int i = 0; i < NumKw; i++) begin
      if (cands[i] && (idx < LenBits'(KwLen[i])) &&
          (KwText[i][(63 - 8*int'(idx[2:0])) -: 8] == c)) begin
        keep[i] = 1'b1;
      end
    end
    return keep;
  endfunction

  function automatic logic kw_hit(input logic [NumKw-1:0] cands,
                                  input logic [LenBits-1:0] len);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumKw; i++) begin
      if (cands[i] && (len == LenBits'(KwLen[i]))) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic [LenBits-1:0] len_inc(input logic [LenBits-1:0] len);
    return (&len) ? len : len + LenBits'(1);
  endfunction

  function automatic logic [CntBits-1:0] cnt_add(input logic [CntBits-1:0] a,
                                                 input logic [3:0] b);
    logic [CntBits:0] s;
    s = {1'b0, a} + (CntBits+1)'(b);
    return s[CntBits] ? '1 : s[CntBits-1:0];
  endfunction

  function automatic token_t mk_tok(input tok_kind_t kind,
                                    input logic [CntBits-1:0] ln,
                                    input logic [CntBits-1:0] col,
                                    input logic [LenBits-1:0] len,
                                    input logic [7:0] fb);
    token_t t;
    t.kind       = kind;
    t.line       = sat_out(ln);
    t.column     = sat_out(col);
    t.length     = OutBits'(len);
    t.first_byte = fb;
    t.last       = 1'b0;
    return t;
  endfunction

  pend_kind_t         pend_kind, pend_kind_next;
  logic [NumKw-1:0]   kw_cands, kw_cands_next;
  logic [LenBits-1:0] pend_len, pend_len_next;
  logic [7:0]         pend_fb, pend_fb_next;
  logic [CntBits-1:0] start_line, start_line_next;
  logic [CntBits-1:0] start_col, start_col_next;
  logic [CntBits-1:0] cur_line, cur_line_next;
  logic [CntBits-1:0] cur_col, cur_col_next;

  logic       consumed;
  logic       do_begin;
  pend_kind_t begin_kind;
  pend_kind_t op_kind;
  logic [7:0] c;

  assign c = char_code;

  always_comb begin
    case (c)
      ChPlus:  op_kind = PK_PLUS;
      ChMinus: op_kind = PK_MINUS;
      ChStar:  op_kind = PK_STAR;
      ChEq:    op_kind = PK_EQ;
      ChGt:    op_kind = PK_GT;
      ChLt:    op_kind = PK_LT;
      default: op_kind = PK_NONE;
    endcase
  end

  always_comb begin
    pend_kind_next  = pend_kind;
    kw_cands_next   = kw_cands;
    pend_len_next   = pend_len;
    pend_fb_next    = pend_fb;
    start_line_next = start_line;
    start_col_next  = start_col;
    consumed        = 1'b0;
    do_begin        = 1'b0;
    begin_kind      = PK_NONE;
    push            = '0;

    // close or extend the pending token
    case (pend_kind)
      PK_WORD: begin
        if (is_alpha(c) || c == ChUnder) begin
          kw_cands_next = kw_filter(kw_cands, pend_len, c);
          pend_len_next = len_inc(pend_len);
          consumed      = 1'b1;
        end else begin
          push.pend_valid = 1'b1;
          push.pend_tok   = mk_tok(kw_hit(kw_cands, pend_len) ? TK_KEYWORD : TK_IDENT,
                                   start_line, start_col, pend_len, pend_fb);
        end
      end
      PK_NUMBER: begin
        if (is_digit(c)) begin
          pend_len_next = len_inc(pend_len);
          consumed      = 1'b1;
        end else begin
          push.pend_valid = 1'b1;
          push.pend_tok   = mk_tok(TK_NUMBER, start_line, start_col, pend_len, pend_fb);
        end
      end
      PK_STRING: begin
        if (c == ChNul) begin
          push.pend_valid = 1'b1;
          push.pend_tok   = mk_tok(TK_INVALID, start_line, start_col, pend_len, pend_fb);
        end else begin
          pend_len_next = len_inc(pend_len);
          consumed      = 1'b1;
          if (c == ChQuote) begin
            push.pend_valid = 1'b1;
            push.pend_tok   = mk_tok(TK_STRING, start_line, start_col,
                                     len_inc(pend_len), pend_fb);
          end
        end
      end
      PK_PLUS: begin
        push.pend_valid = 1'b1;
        consumed        = (c == ChPlus);
        push.pend_tok   = mk_tok(consumed ? TK_INC : TK_PLUS, start_line, start_col,
                                 consumed ? LenBits'(2) : LenBits'(1), pend_fb);
      end
      PK_MINUS: begin
        push.pend_valid = 1'b1;
        consumed        = (c == ChMinus);
        push.pend_tok   = mk_tok(consumed ? TK_DEC : TK_MINUS, start_line, start_col,
                                 consumed ? LenBits'(2) : LenBits'(1), pend_fb);
      end
      PK_STAR: begin
        push.pend_valid = 1'b1;
        consumed        = (c == ChStar);
        push.pend_tok   = mk_tok(consumed ? TK_EXP : TK_MUL, start_line, start_col,
                                 consumed ? LenBits'(2) : LenBits'(1), pend_fb);
      end
      PK_EQ: begin
        push.pend_valid = 1'b1;
        consumed        = (c == ChEq);
        push.pend_tok   = mk_tok(consumed ? TK_EQUAL : TK_ASSIGN, start_line, start_col,
                                 consumed ? LenBits'(2) : LenBits'(1), pend_fb);
      end
      PK_GT: begin
        push.pend_valid = 1'b1;
        consumed        = (c == ChEq);
        push.pend_tok   = mk_tok(consumed ? TK_GTE : TK_INVALID, start_line, start_col,
                                 consumed ? LenBits'(2) : LenBits'(1), pend_fb);
      end
      PK_LT: begin
        push.pend_valid = 1'b1;
        consumed        = (c == ChEq);
        push.pend_tok   = mk_tok(consumed ? TK_LTE : TK_INVALID, start_line, start_col,
                                 consumed ? LenBits'(2) : LenBits'(1), pend_fb);
      end
      default: begin
      end
    endcase

    // token closed: drop pending state
    if (push.pend_valid) begin
      pend_kind_next = PK_NONE;
      pend_len_next  = '0;
      pend_fb_next   = '0;
      kw_cands_next  = '1;
    end

    // byte not absorbed: start a new token, emit a one-byte or eof token, or skip whitespace
    if (!consumed) begin
      if (op_kind != PK_NONE) begin
        do_begin   = 1'b1;
        begin_kind = op_kind;
      end else if (c == ChSpace || c == ChTab || c == ChLf || c == ChCr) begin
        do_begin = 1'b0;
      end else if (c == ChNul) begin
        push.new_valid = 1'b1;
        push.new_tok   = mk_tok(TK_EOF, cur_line, cur_col, '0, '0);
      end else if (c == ChQuote) begin
        do_begin   = 1'b1;
        begin_kind = PK_STRING;
      end else if (is_alpha(c)) begin
        do_begin   = 1'b1;
        begin_kind = PK_WORD;
      end else if (is_digit(c)) begin
        do_begin   = 1'b1;
        begin_kind = PK_NUMBER;
      end else begin
        push.new_valid = 1'b1;
        case (c)
          ChSlash: push.new_tok = mk_tok(TK_SLASH, cur_line, cur_col, LenBits'(1), c);
          ChLpar:  push.new_tok = mk_tok(TK_LPAREN, cur_line, cur_col, LenBits'(1), c);
          ChRpar:  push.new_tok = mk_tok(TK_RPAREN, cur_line, cur_col, LenBits'(1), c);
          ChLbr:   push.new_tok = mk_tok(TK_LBRACE, cur_line, cur_col, LenBits'(1), c);
          ChRbr:   push.new_tok = mk_tok(TK_RBRACE, cur_line, cur_col, LenBits'(1), c);
          ChSemi:  push.new_tok = mk_tok(TK_SEMI, cur_line, cur_col, LenBits'(1), c);
          default: push.new_tok = mk_tok(TK_INVALID, cur_line, cur_col, LenBits'(1), c);
        endcase
      end
    end

    if (do_begin) begin
      pend_kind_next  = begin_kind;
      pend_fb_next    = c;
      pend_len_next   = LenBits'(1);
      start_line_next = cur_line;
      start_col_next  = cur_col;
      kw_cands_next   = kw_filter('1, '0, c);
    end

    push.new_tok.last  = 1'b1;
    push.pend_tok.last = !push.new_valid;
  end

  // position of the next byte
  always_comb begin
    cur_line_next = cur_line;
    cur_col_next  = cur_col;
    if (c == ChLf) begin
      cur_line_next = cnt_add(cur_line, 4'd1);
      cur_col_next  = CntBits'(1);
    end else if (c == ChTab) begin
      cur_col_next = cnt_add(cur_col, tab_width);
    end else if (c != ChNul) begin
      cur_col_next = cnt_add(cur_col, 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_kind  <= PK_NONE;
      kw_cands   <= '1;
      pend_len   <= '0;
      pend_fb    <= '0;
      start_line <= CntBits'(1);
      start_col  <= CntBits'(1);
      cur_line   <= CntBits'(1);
      cur_col    <= CntBits'(1);
    end else if (step) begin
      pend_kind  <= pend_kind_next;
      kw_cands   <= kw_cands_next;
      pend_len   <= pend_len_next;
      pend_fb    <= pend_fb_next;
      start_line <= start_line_next;
      start_col  <= start_col_next;
      cur_line   <= cur_line_next;
      cur_col    <= cur_col_next;
    end
  end

endmodule

/* rtl/core/ctsk_out_queue.sv */
// result queue: takes up to two tokens per cycle, hands out one per cycle while out_ready is high
// depends on ctsk_pkg
module ctsk_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_en,
  input  ctsk_pkg::tok_push_t push,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output ctsk_pkg::token_t    out_tok
);
  import ctsk_pkg::*;

  token_t              mem [QDepth];
  logic [QPtrBits-1:0] wr_ptr;
  logic [QPtrBits-1:0] rd_ptr;
  logic [QPtrBits:0]   count;
  logic                wr_a;
  logic                wr_b;
  logic                pop;
  token_t              first_tok;
  logic [QPtrBits:0]   n_push;

  assign wr_a      = push_en && push.pend_valid;
  assign wr_b      = push_en && push.new_valid;
  assign first_tok = wr_a ? push.pend_tok : push.new_tok;
  assign n_push    = (QPtrBits+1)'(wr_a) + (QPtrBits+1)'(wr_b);
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_tok   = mem[rd_ptr];
  assign space_ok  = (count <= (QPtrBits+1)'(QDepth - 2));

  always_ff @(posedge clk) begin
    if (wr_a || wr_b) begin
      mem[wr_ptr] <= first_tok;
    end
    if (wr_a && wr_b) begin
      mem[wr_ptr + QPtrBits'(1)] <= push.new_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPtrBits'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrBits'(1);
      end
      count <= count + n_push - (QPtrBits+1)'(pop);
    end
  end

endmodule

/* rtl/core/char_stream_tokenizer_top.sv */
// character stream tokenizer: one source byte in per cycle while in_ready is high, up to two tokens out
// tokens are written into the result queue on the edge that accepts the byte completing them
// throughput: one byte per cycle while the result queue has room for two tokens; a byte giving two
// tokens hands them out one at a time, set by the single-token output port and the four-entry result queue
// reset: synchronous, clears tokenizer state to line 1 column 1, empties the queue, tab width 4
module char_stream_tokenizer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    char_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    token_kind,
  output logic [15:0]                   token_line,
  output logic [15:0]                   token_column,
  output logic [15:0]                   token_length,
  output logic [7:0]                    first_byte,
  output logic                          last_in_run,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctsk_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ctsk_pkg::*;

  logic      [3:0] tab_width;
  logic            step;
  tok_push_t       push;
  token_t          out_tok;

  assign step = in_valid && in_ready;

  ctsk_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .tab_width (tab_width)
  );

  ctsk_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_code (char_code),
    .tab_width (tab_width),
    .push      (push)
  );

  ctsk_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (step),
    .push      (push),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok)
  );

  assign token_kind   = out_tok.kind;
  assign token_line   = out_tok.line;
  assign token_column = out_tok.column;
  assign token_length = out_tok.length;
  assign first_byte   = out_tok.first_byte;
  assign last_in_run  = out_tok.last;

endmodule

/* rtl/core/ctsk_checker.sv */
// port-level checks of the character stream tokenizer, bound to the top level
// depends on ctsk_pkg and char_stream_tokenizer_top
module ctsk_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  token_kind,
  input logic [15:0] token_line,
  input logic [15:0] token_column,
  input logic [15:0] token_length,
  input logic [7:0]  first_byte,
  input logic        last_in_run
);
  import ctsk_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(token_line) &&
      $stable(token_column) && $stable(token_length) && $stable(first_byte))
    else $error("result changed while stalled");

  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == TK_EOF |-> token_length == '0 && first_byte == '0 && last_in_run)
    else $error("eof token malformed");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != TK_EOF |-> token_length != '0)
    else $error("token with zero length");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_line != '0 && token_column != '0)
    else $error("token position zero");

endmodule

bind char_stream_tokenizer_top ctsk_checker u_ctsk_checker (.*);

/* test/tb_top.sv */
// testbench for char_stream_tokenizer_top: feeds source bytes over valid/ready, writes
// tab_width over apb and checks every token against a tokenizer predictor held here
// depends on ctsk_pkg and the tokenizer rtl
`timescale 1ns / 100ps

module tb_top;
  import ctsk_pkg::*;

  typedef enum logic [3:0] {
    PEND_NONE, PEND_WORD, PEND_NUMBER, PEND_STRING,
    PEND_PLUS, PEND_MINUS, PEND_STAR, PEND_EQ, PEND_GT, PEND_LT
  } pend_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  localparam logic [AddrBits-1:0] TabWidthAddr = {RegTabWidth, 2'b00};
  localparam int RandomChars = 1600;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChQuote = 8'h22;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          char_code = 8'd0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [4:0]          token_kind;
  logic [15:0]         token_line;
  logic [15:0]         token_column;
  logic [15:0]         token_length;
  logic [7:0]          first_byte;
  logic                last_in_run;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // predictor state
  logic [3:0]  tab_cols;
  pend_t       pend_kind;
  logic [4:0]  kw_live;
  logic [15:0] pend_len;
  logic [7:0]  pend_first;
  logic [15:0] start_ln;
  logic [15:0] start_col;
  logic [15:0] line_now;
  logic [15:0] col_now;
  token_t      predicted_tokens [$];

  int       mismatches = 0;
  int       chars_sent = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b1;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_count = 0;

  char_stream_tokenizer_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_code   (char_code),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .token_kind  (token_kind),
    .token_line  (token_line),
    .token_column(token_column),
    .token_length(token_length),
    .first_byte  (first_byte),
    .last_in_run (last_in_run),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic string keyword_text(input int k);
    case (k)
      0: return "function";
      1: return "print";
      2: return "if";
      3: return "else";
      default: return "elseif";
    endcase
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [4:0] keyword_filter(input logic [4:0] live, input logic [15:0] idx,
                                                input logic [7:0] c);
    logic [4:0] keep;
    string      w;
    keep = '0;
    for (int k = 0; k < 5; k++) begin
      w = keyword_text(k);
      if (live[k] && idx < w.len() && w[idx] == c) keep[k] = 1'b1;
    end
    return keep;
  endfunction

  function automatic bit word_is_keyword();
    string w;
    for (int k = 0; k < 5; k++) begin
      w = keyword_text(k);
      if (kw_live[k] && w.len() == pend_len) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic token_t make_token(input tok_kind_t kind, input logic [15:0] ln,
                                        input logic [15:0] col, input logic [15:0] len,
                                        input logic [7:0] fb);
    token_t t;
    t.kind       = kind;
    t.line       = ln;
    t.column     = col;
    t.length     = len;
    t.first_byte = fb;
    t.last       = 1'b0;
    return t;
  endfunction

  task automatic clear_pending();
    pend_kind  = PEND_NONE;
    pend_len   = 16'd0;
    pend_first = 8'd0;
    kw_live    = 5'h1F;
  endtask

  task automatic start_pending(input pend_t p, input logic [7:0] c);
    pend_kind  = p;
    pend_first = c;
    pend_len   = 16'd1;
    start_ln   = line_now;
    start_col  = col_now;
    kw_live    = keyword_filter(5'h1F, 16'd0, c);
  endtask

  task automatic bump_length();
    if (pend_len != 16'hFFFF) pend_len = pend_len + 16'd1;
  endtask

  task automatic reset_tokenizer_model();
    tab_cols  = TabReset;
    clear_pending();
    start_ln  = 16'd1;
    start_col = 16'd1;
    line_now  = 16'd1;
    col_now   = 16'd1;
  endtask

  // tokens caused by one source byte, appended to predicted_tokens
  task automatic tokenize_byte(input logic [7:0] c);
    token_t     run [2];
    int         n;
    bit         taken;
    bit         lone;
    tok_kind_t  one;
    logic [7:0] op2;
    tok_kind_t  dbl;
    tok_kind_t  sgl;
    n = 0;
    taken = 1'b0;
    lone = 1'b0;
    one = TK_INVALID;
    op2 = 8'd0;
    dbl = TK_INVALID;
    sgl = TK_INVALID;
    case (pend_kind)
      PEND_PLUS: begin
        op2 = "+"; dbl = TK_INC; sgl = TK_PLUS;
      end
      PEND_MINUS: begin
        op2 = "-"; dbl = TK_DEC; sgl = TK_MINUS;
      end
      PEND_STAR: begin
        op2 = "*"; dbl = TK_EXP; sgl = TK_MUL;
      end
      PEND_EQ: begin
        op2 = "="; dbl = TK_EQUAL; sgl = TK_ASSIGN;
      end
      PEND_GT: begin
        op2 = "="; dbl = TK_GTE; sgl = TK_INVALID;
      end
      PEND_LT: begin
        op2 = "="; dbl = TK_LTE; sgl = TK_INVALID;
      end
      default: ;
    endcase

    if (pend_kind == PEND_WORD) begin
      if (is_alpha(c) || c == "_") begin
        kw_live = keyword_filter(kw_live, pend_len, c);
        bump_length();
        taken = 1'b1;
      end else begin
        run[n] = make_token(word_is_keyword() ? TK_KEYWORD : TK_IDENT, start_ln, start_col,
                            pend_len, pend_first);
        n++;
        clear_pending();
      end
    end else if (pend_kind == PEND_NUMBER) begin
      if (is_digit(c)) begin
        bump_length();
        taken = 1'b1;
      end else begin
        run[n] = make_token(TK_NUMBER, start_ln, start_col, pend_len, pend_first);
        n++;
        clear_pending();
      end
    end else if (pend_kind == PEND_STRING) begin
      if (c == ChNul) begin
        // unterminated string
        run[n] = make_token(TK_INVALID, start_ln, start_col, pend_len, pend_first);
        n++;
        clear_pending();
      end else begin
        bump_length();
        taken = 1'b1;
        if (c == ChQuote) begin
          run[n] = make_token(TK_STRING, start_ln, start_col, pend_len, pend_first);
          n++;
          clear_pending();
        end
      end
    end else if (pend_kind != PEND_NONE) begin
      if (c == op2) begin
        run[n] = make_token(dbl, start_ln, start_col, 16'd2, pend_first);
        taken = 1'b1;
      end else begin
        run[n] = make_token(sgl, start_ln, start_col, 16'd1, pend_first);
      end
      n++;
      clear_pending();
    end

    if (!taken) begin
      case (c)
        "+": start_pending(PEND_PLUS, c);
        "-": start_pending(PEND_MINUS, c);
        "*": start_pending(PEND_STAR, c);
        "=": start_pending(PEND_EQ, c);
        ">": start_pending(PEND_GT, c);
        "<": start_pending(PEND_LT, c);
        " ", ChTab, ChLf, ChCr: ;
        ChNul: begin
          run[n] = make_token(TK_EOF, line_now, col_now, 16'd0, 8'd0);
          n++;
        end
        ChQuote: start_pending(PEND_STRING, c);
        "/": begin
          lone = 1'b1; one = TK_SLASH;
        end
        "(": begin
          lone = 1'b1; one = TK_LPAREN;
        end
        ")": begin
          lone = 1'b1; one = TK_RPAREN;
        end
        "{": begin
          lone = 1'b1; one = TK_LBRACE;
        end
        "}": begin
          lone = 1'b1; one = TK_RBRACE;
        end
        ";": begin
          lone = 1'b1; one = TK_SEMI;
        end
        default: begin
          if (is_alpha(c)) start_pending(PEND_WORD, c);
          else if (is_digit(c)) start_pending(PEND_NUMBER, c);
          else lone = 1'b1;
        end
      endcase
      if (lone) begin
        run[n] = make_token(one, line_now, col_now, 16'd1, c);
        n++;
      end
    end

    if (c == ChLf) begin
      line_now = sat_add(line_now, 16'd1);
      col_now  = 16'd1;
    end else if (c == ChTab) begin
      col_now = sat_add(col_now, 16'(tab_cols));
    end else if (c != ChNul) begin
      col_now = sat_add(col_now, 16'd1);
    end

    if (n > 0) run[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) predicted_tokens.push_back(run[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result side: compare at the falling edge, the transfer completes at the next rising edge
  always @(negedge clk) begin
    token_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (predicted_tokens.size() == 0) begin
        mismatches++;
        $display("%0t extra token: expected none actual kind %0d line %0d column %0d",
                 $time, token_kind, token_line, token_column);
      end else begin
        want = predicted_tokens.pop_front();
        check_field("token_kind", want.kind, token_kind);
        check_field("token_line", want.line, token_line);
        check_field("token_column", want.column, token_column);
        check_field("token_length", want.length, token_length);
        check_field("first_byte", want.first_byte, first_byte);
        check_field("last_in_run", want.last, last_in_run);
      end
    end
  end

  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_count % 300 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_ready <= (rx_count % 5 == 0);
      default:   out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_char(input logic [7:0] c);
    in_valid  <= 1'b1;
    char_code <= c;
    do @(negedge clk); while (in_ready !== 1'b1);
    @(posedge clk);
    tokenize_byte(c);
    chars_sent++;
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(0, 12);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (predicted_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TabWidthAddr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdata = prdata;
      done  = (pready === 1'b1);
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_tab_width(input logic [3:0] w);
    logic [31:0] rd;
    wait_drained();
    apb_cycle(1'b1, {28'd0, w}, rd);
    tab_cols = w;
    @(posedge clk);
    apb_cycle(1'b0, 32'd0, rd);
    check_field("tab_width", {28'd0, w}, rd);
  endtask

  function automatic logic [7:0] pick_byte(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic logic [7:0] random_letter();
    if ($urandom_range(0, 1) == 1) return "a" + 8'($urandom_range(0, 25));
    return "A" + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_word_char();
    if ($urandom_range(0, 7) == 0) return "_";
    return random_letter();
  endfunction

  function automatic logic [7:0] random_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] whitespace_byte();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return ChTab;
      2: return ChLf;
      default: return ChCr;
    endcase
  endfunction

  function automatic logic [7:0] string_byte(input bit allow_lf);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == ChQuote || (!allow_lf && b == ChLf));
    return b;
  endfunction

  // mostly well formed lexemes, with stray bytes and broken strings mixed in
  task automatic send_fragment();
    string w;
    int    len;
    logic [7:0] b;
    case ($urandom_range(0, 15))
      0, 1: begin
        w = keyword_text($urandom_range(0, 4));
        len = w.len();
        if ($urandom_range(0, 3) == 0) len = $urandom_range(1, w.len());
        for (int i = 0; i < len; i++) send_char(w[i]);
        if ($urandom_range(0, 3) == 0) send_char(random_word_char());
      end
      2, 3: begin
        send_char(random_letter());
        repeat ($urandom_range(0, 9)) send_char(random_word_char());
      end
      4: repeat ($urandom_range(1, 6)) send_char(random_digit());
      5: begin
        send_char(ChQuote);
        repeat ($urandom_range(0, 8)) send_char(string_byte(1'b1));
        send_char(ChQuote);
      end
      6, 7: begin
        b = pick_byte("+-*=<>");
        send_char(b);
        case ($urandom_range(0, 2))
          0: send_char(b);
          1: send_char("=");
          default: ;
        endcase
      end
      8: send_char(pick_byte("/(){};"));
      9, 10: repeat ($urandom_range(1, 3)) send_char(whitespace_byte());
      11: send_char(8'($urandom_range(0, 255)));
      12: send_char(ChNul);
      13: begin
        send_char(ChQuote);
        repeat ($urandom_range(0, 5)) send_char(string_byte(1'b1));
        send_char(ChNul);
      end
      14: begin
        send_char(random_letter());
        send_char(random_digit());
      end
      default: send_char(8'($urandom_range(128, 255)));
    endcase
    if ($urandom_range(0, 1) == 0) send_char(whitespace_byte());
  endtask

  task automatic test_reset_defaults();
    logic [31:0] rd;
    apb_cycle(1'b0, 32'd0, rd);
    check_field("tab_width", {28'd0, TabReset}, rd);
    send_char(ChNul);
  endtask

  task automatic test_directed_tokens();
    send_text("if");
    send_char(8'hFF);
    send_text("<=>a/");
    send_char(ChQuote);
    send_text("x");
    send_char(ChNul);
    send_text("9*");
    send_char(ChTab);
    send_text("**--++==;");
    send_char(ChNul);
    wait_drained();
  endtask

  task automatic test_tab_widths();
    logic [3:0] widths [5];
    widths = '{4'd0, 4'd1, 4'd8, 4'd15, TabReset};
    for (int i = 0; i < 5; i++) begin
      set_tab_width(widths[i]);
      send_char(ChTab);
      send_text("x");
      send_char(ChLf);
    end
    wait_drained();
  endtask

  task automatic test_random_stream();
    logic [3:0] widths [5];
    int         target;
    widths = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2};
    widths[4] = 4'($urandom_range(0, 15));
    for (int ph = 0; ph < 5; ph++) begin
      set_tab_width(widths[ph]);
      target = chars_sent + RandomChars / 5;
      while (chars_sent < target) begin
        send_fragment();
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end
    wait_drained();
  endtask

  // long string sent back to back, then a word right after it
  task automatic test_long_string();
    gaps_on = 1'b0;
    send_char(ChQuote);
    repeat (120) send_char(string_byte(1'b0));
    send_char(ChQuote);
    send_text("x");
    send_char(ChLf);
    gaps_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    reset_tokenizer_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_tokens();
    test_tab_widths();
    test_random_stream();
    test_long_string();
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && predicted_tokens.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
